### rtl/signed_int_to_decimal_text_macros.svh
// assertion helpers shared by the checker
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_MACROS_SVH

// same-cycle implication
`define SIDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sidt check failed");

// next-cycle implication
`define SIDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sidt check failed");

`endif

### rtl/sidt_pkg.sv
package sidt_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned DigitCount = 10;
    localparam int unsigned DigitIdxW  = 4;
    localparam int unsigned StepCntW   = 5;

    localparam logic [CharWidth-1:0]  CharMinus = 8'h2D;
    localparam logic [CharWidth-1:0]  CharZero  = 8'h30;
    localparam logic [StepCntW-1:0]   LastStep  = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } sidt_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic set_index;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_last;
        logic negative;
        logic idx_zero;
        logic slot_free;
    } dp_status_t;

endpackage

### rtl/sidt_ctrl.sv
module sidt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sidt_pkg::dp_status_t status,
    output sidt_pkg::dp_cmd_t   cmd
);
    import sidt_pkg::*;

    sidt_state_t state_reg;
    sidt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (status.step_last)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!status.negative || status.slot_free)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (status.slot_free && status.idx_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.set_index = 1'b1;
                cmd.emit_sign = status.negative && status.slot_free;
            end
            ST_DIGITS:
            begin
                cmd.emit_digit = status.slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/sidt_datapath.sv
module sidt_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [sidt_pkg::ValueWidth-1:0]       value,
    input  sidt_pkg::dp_cmd_t                     cmd,
    output sidt_pkg::dp_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sidt_pkg::CharWidth-1:0]        out_char,
    output logic                                  out_last
);
    import sidt_pkg::*;

    logic [ValueWidth-1:0]            mag_reg;
    logic [ValueWidth-1:0]            mag_next;
    logic [DigitCount-1:0][3:0]       bcd_reg;
    logic [DigitCount-1:0][3:0]       bcd_next;
    logic [DigitCount-1:0][3:0]       bcd_adj;
    logic                             neg_reg;
    logic                             neg_next;
    logic [StepCntW-1:0]              cnt_reg;
    logic [StepCntW-1:0]              cnt_next;
    logic [DigitIdxW-1:0]             idx_reg;
    logic [DigitIdxW-1:0]             idx_next;
    logic [DigitIdxW-1:0]             msd_idx;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [CharWidth-1:0]             out_char_reg;
    logic [CharWidth-1:0]             out_char_next;
    logic                             out_last_reg;
    logic                             out_last_next;
    logic                             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DigitCount; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    // highest non-zero digit, zero gives the units digit
    always_comb
    begin
        msd_idx = '0;
        for (int i = 0; i < DigitCount; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                msd_idx = DigitIdxW'(i);
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (cmd.load)
        begin
            neg_next = value[ValueWidth-1];
            mag_next = value[ValueWidth-1] ? (ValueWidth'(0) - value) : value;
            bcd_next = '0;
            cnt_next = '0;
        end
        else if (cmd.shift)
        begin
            {bcd_next, mag_next} = {bcd_adj, mag_reg} << 1;
            cnt_next             = cnt_reg + StepCntW'(1);
        end

        if (cmd.set_index)
        begin
            idx_next = msd_idx;
        end
        else if (cmd.emit_digit)
        begin
            idx_next = idx_reg - DigitIdxW'(1);
        end

        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CharMinus;
            out_last_next  = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CharZero + {4'd0, bcd_reg[idx_reg]};
            out_last_next  = (idx_reg == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign status.step_last = (cnt_reg == LastStep);
    assign status.negative  = neg_reg;
    assign status.idx_zero  = (idx_reg == '0);
    assign status.slot_free = slot_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/signed_int_to_decimal_text.sv
// Formats one 32-bit two's complement integer per input word as decimal ASCII
// text, one character per output word: a leading '-' for negative values, then
// the magnitude most significant digit first with no leading zeros (zero gives
// "0"); m_tlast marks the final character. The magnitude is converted to BCD by
// a shift-and-add-three loop that runs one bit a cycle. An item passes through
// an accept step, the conversion loop, a step that issues the sign if there
// is one, then its digits (1 to 10), one per cycle while the output side does
// not stall. Stalls on m_tready stretch the sign and digit phase, each
// character waiting in the output register until it is taken. s_tready is
// high only between items.
module signed_int_to_decimal_text (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [sidt_pkg::ValueWidth-1:0]       s_tdata,   // [31:0] value
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [sidt_pkg::CharWidth-1:0]        m_tdata,   // [7:0] character
    output logic                                  m_tlast
);
    import sidt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sidt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sidt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/sidt_checker.sv
`include "signed_int_to_decimal_text_macros.svh"

module sidt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sidt_pkg::CharWidth-1:0]      m_tdata,
    input logic                                m_tlast
);
    import sidt_pkg::*;

    // a held word keeps its payload
    `SIDT_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // only a minus sign or a digit ever leaves
    `SIDT_ASSERT_IMP(a_char_set, clk, rst_n, m_tvalid,
                     (m_tdata == CharMinus) ||
                     ((m_tdata >= CharZero) && (m_tdata <= (CharZero + 8'd9))))

    // the sign never ends the text
    `SIDT_ASSERT_IMP(a_sign_not_last, clk, rst_n, m_tvalid && (m_tdata == CharMinus),
                     !m_tlast)

    // conversion keeps the input side closed after a word is taken
    `SIDT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind signed_int_to_decimal_text sidt_checker u_sidt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/tb_signed_int_to_decimal_text.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_text;

    import sidt_pkg::*;

    localparam int unsigned Radix      = 10;
    localparam int unsigned LongStall  = 300;
    localparam int unsigned TailCycles = 60;
    localparam int unsigned CycleLimit = 200000;

    typedef struct packed {
        logic [CharWidth-1:0] code;
        logic                 last;
    } text_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ValueWidth-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CharWidth-1:0]  m_tdata;
    logic                  m_tlast;

    logic [ValueWidth-1:0] pending_values[$];
    text_char_t            expected_text[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    int stall_left = 0;
    int error_count = 0;
    int values_accepted = 0;
    int negatives_accepted = 0;
    int chars_checked = 0;
    int cycle_count = 0;

    signed_int_to_decimal_text dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // expected text of one value: optional sign, then digits msd first
    function automatic void format_decimal(input logic [ValueWidth-1:0] value);
        logic [ValueWidth-1:0] magnitude;
        logic [3:0]            digits[DigitCount];
        int                    count;
        text_char_t            ch;
        magnitude = value[ValueWidth-1] ? -value : value;
        count = 0;
        do
        begin
            digits[count] = 4'(magnitude % Radix);
            count++;
            magnitude = magnitude / Radix;
        end
        while (magnitude != 0);
        if (value[ValueWidth-1])
        begin
            ch.code = CharMinus;
            ch.last = 1'b0;
            expected_text.push_back(ch);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            ch.code = CharZero + {4'd0, digits[i]};
            ch.last = (i == 0);
            expected_text.push_back(ch);
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                format_decimal(s_tdata);
                values_accepted++;
                if (s_tdata[ValueWidth-1])
                    negatives_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_values.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and output-side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word char=%h last=%b", $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_text.pop_front();
                    chars_checked++;
                    if (m_tdata !== want.code)
                    begin
                        error_count++;
                        $display("%0t: char mismatch expected=%h actual=%h",
                                 $time, want.code, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last mismatch expected=%b actual=%b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (stall_requests != stalls_served)
            begin
                stall_left    <= LongStall;
                stalls_served <= stalls_served + 1;
                m_tready      <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_text.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // sender pauses here until every character has come back
    task automatic wait_for_drain();
        while (pending_values.size() != 0 || s_tvalid || expected_text.size() != 0)
            @(negedge clk);
    endtask

    // random values: shifted right to vary digit count, maybe negated, 1 in 20 raw
    task automatic run_random(input int count, input int send_pct, input int recv_pct,
                              input bit long_stall);
        logic [ValueWidth-1:0] v;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            v = $urandom >> $urandom_range(31, 0);
            if ($urandom_range(1))
                v = -v;
            if ($urandom_range(19) == 0)
                v = $urandom;
            pending_values.push_back(v);
        end
        if (long_stall)
            stall_requests++;
        wait_for_drain();
    endtask

    initial
    begin
        logic [ValueWidth-1:0] directed[$];
        directed = '{32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
                     32'd1000000000, -32'd1000000000, 32'd999999999, 32'd1000000001,
                     32'd123456789, -32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd4294967286, 32'd2000000000};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (directed[i])
            pending_values.push_back(directed[i]);
        wait_for_drain();

        run_random(69, 10, 66, 1'b0);
        run_random(69, 66, 10, 1'b0);
        run_random(69, 0, 0, 1'b1);

        repeat (TailCycles) @(negedge clk);
        $display("converted %0d values (%0d negative), checked %0d characters",
                 values_accepted, negatives_accepted, chars_checked);
        $display("idle mixes on both sides plus one %0d-cycle output stall", LongStall);
        if (error_count == 0 && expected_text.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### signed_int_to_decimal_text.f
+incdir+rtl
rtl/sidt_pkg.sv
rtl/sidt_ctrl.sv
rtl/sidt_datapath.sv
rtl/signed_int_to_decimal_text.sv
rtl/sidt_checker.sv
tb/tb_signed_int_to_decimal_text.sv
